@@ rtl/pcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_pkg: shared constants, types and helpers for the periodic wrap block
// Fixed-point formats, register indexes, mode codes and the queue payload.
// ----------------------------------------------------------------------------
package pcw_pkg;

	localparam int POS_BITS  = 32;
	localparam int MAT_BITS  = 21;
	localparam int REG_W     = 63;
	localparam int NORM_BITS = 63;
	localparam int FRAC_BITS = 28;
	localparam int MAT_FRAC  = 12;
	localparam int POS_FRAC  = 16;

	localparam int D_W    = POS_BITS + 1;
	localparam int FR_W   = FRAC_BITS + 2;
	localparam int PROD_W = MAT_BITS + FR_W;
	localparam int S_W    = PROD_W + 3;
	localparam int SHIFT  = FRAC_BITS + MAT_FRAC - POS_FRAC;
	localparam int Q_W    = S_W - SHIFT;
	localparam int SQ_W   = 2 * Q_W;
	localparam int NRM_W  = SQ_W + 2;

	localparam int IMG_CNT    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic signed [63:0] PMAX = (64'sd1 <<< (POS_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] PMIN = -PMAX - 64'sd1;

	localparam logic [1:0] MODE_POSITIVE = 2'd0;
	localparam logic [1:0] MODE_ORIGIN   = 2'd1;
	localparam logic [1:0] MODE_VORONOI  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_A  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_C  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_A   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_B   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INV_C   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd7;

	typedef logic [REG_W-1:0] reg_t;

	// centered fractions of one item, Q.28 with headroom
	typedef struct packed {
		logic [2:0][FR_W-1:0] fr;
	} frv_t;

	function automatic logic signed [MAT_BITS-1:0] mat_entry(reg_t r, logic [1:0] idx);
		return r[idx*MAT_BITS +: MAT_BITS];
	endfunction

endpackage

@@ rtl/pcw_pos_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_pos_if: position channel
// Valid/ready channel carrying one Q16.16 position per transfer.
// ----------------------------------------------------------------------------
interface pcw_pos_if;
	logic valid;
	logic ready;
	logic signed [pcw_pkg::POS_BITS-1:0] pos_x;
	logic signed [pcw_pkg::POS_BITS-1:0] pos_y;
	logic signed [pcw_pkg::POS_BITS-1:0] pos_z;

	modport source(output valid, pos_x, pos_y, pos_z, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

@@ rtl/pcw_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_res_if: result channel
// Valid/ready channel carrying one wrapped position and its squared norm.
// ----------------------------------------------------------------------------
interface pcw_res_if;
	logic valid;
	logic ready;
	logic signed [pcw_pkg::POS_BITS-1:0] out_x;
	logic signed [pcw_pkg::POS_BITS-1:0] out_y;
	logic signed [pcw_pkg::POS_BITS-1:0] out_z;
	logic [pcw_pkg::NORM_BITS-1:0] sq_norm;

	modport source(output valid, out_x, out_y, out_z, sq_norm, input ready);
	modport sink(input valid, out_x, out_y, out_z, sq_norm, output ready);
endinterface

@@ rtl/pcw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_front: centering and fractional mapping
// Subtract the center, map through the inverse cell modulo one and center the
// fractions; three stages feeding the queue.
// ----------------------------------------------------------------------------
module pcw_front (
	input  logic                clk,
	input  logic                arst_n,
	pcw_pos_if.sink             pos,
	input  logic [1:0]          mode,
	input  pcw_pkg::reg_t [2:0] inv,
	input  pcw_pkg::reg_t       center,
	output logic                push,
	output pcw_pkg::frv_t       push_data,
	input  logic                full
);

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	logic signed [pcw_pkg::D_W-1:0] d_s1 [3];
	logic [pcw_pkg::FRAC_BITS-1:0] prod_s2 [3][3];
	logic [2:0][pcw_pkg::FR_W-1:0] fr_s3;
	logic signed [pcw_pkg::D_W-1:0] d_c [3];
	logic signed [pcw_pkg::POS_BITS-1:0] p_c [3];
	logic [pcw_pkg::FRAC_BITS-1:0] prod_c [3][3];
	logic [2:0][pcw_pkg::FR_W-1:0] fr_c;

	assign adv3      = !v_s3 || !full;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign pos.ready = adv1;
	assign push      = v_s3 && !full;
	assign push_data = '{fr: fr_s3};

	assign p_c[0] = pos.pos_x;
	assign p_c[1] = pos.pos_y;
	assign p_c[2] = pos.pos_z;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			d_c[j] = pcw_pkg::D_W'(p_c[j])
				- (pcw_pkg::D_W'(pcw_pkg::mat_entry(center, 2'(j))) <<< 4);
		end
	end

	// only the low fraction bits survive, so multiply modulo 2^FRAC_BITS
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_c[i][j] = pcw_pkg::FRAC_BITS'(pcw_pkg::mat_entry(inv[i], 2'(j)))
					* d_s1[j][pcw_pkg::FRAC_BITS-1:0];
			end
		end
	end

	always_comb begin
		logic [pcw_pkg::FRAC_BITS-1:0] acc;
		logic signed [pcw_pkg::FR_W-1:0] f;
		for (int i = 0; i < 3; i++) begin
			acc = prod_s2[i][0] + prod_s2[i][1] + prod_s2[i][2];
			f   = pcw_pkg::FR_W'($signed(acc));
			if (mode == pcw_pkg::MODE_POSITIVE && f > 0) begin
				f = f + (pcw_pkg::FR_W'(1) <<< pcw_pkg::FRAC_BITS);
			end
			fr_c[i] = f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pos.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) d_s1 <= d_c;
		if (adv2) prod_s2 <= prod_c;
		if (adv3) fr_s3 <= fr_c;
	end

endmodule

@@ rtl/pcw_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_fifo: short queue between front and back
// Register-based queue of fraction vectors; either side stalls on its own.
// ----------------------------------------------------------------------------
module pcw_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pcw_pkg::frv_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output pcw_pkg::frv_t pop_data
);

	pcw_pkg::frv_t mem_q [pcw_pkg::FIFO_DEPTH];
	logic [pcw_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [pcw_pkg::FIFO_CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == pcw_pkg::FIFO_CNT_W'(pcw_pkg::FIFO_DEPTH));
	assign avail    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

@@ rtl/pcw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcw_back: Cartesian mapping, image search and output
// Map fractions through the cell, form the eight images, square and sum; in
// Voronoi mode pick the shortest via a registered tree; saturate into the output.
// ----------------------------------------------------------------------------
module pcw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                avail,
	input  pcw_pkg::frv_t       pop_data,
	output logic                pop,
	input  logic [1:0]          mode,
	input  pcw_pkg::reg_t [2:0] cell_rows,
	pcw_res_if.source           res
);

	localparam int NS = 8;
	localparam logic signed [pcw_pkg::S_W-1:0] RND =
		pcw_pkg::S_W'(1) <<< (pcw_pkg::SHIFT - 1);

	logic [NS-1:0] v_q;
	logic [NS-1:0] adv;
	logic vor;

	logic signed [pcw_pkg::PROD_W-1:0] prod_s1 [3][3];
	logic signed [pcw_pkg::S_W-1:0]    sum_s2 [3];
	logic signed [pcw_pkg::Q_W-1:0]    q_s3 [pcw_pkg::IMG_CNT][3];
	logic signed [pcw_pkg::Q_W-1:0]    q_s4 [pcw_pkg::IMG_CNT][3];
	logic [pcw_pkg::SQ_W-1:0]          sq_s4 [pcw_pkg::IMG_CNT][3];
	logic signed [pcw_pkg::Q_W-1:0]    q_s5 [pcw_pkg::IMG_CNT][3];
	logic [pcw_pkg::NRM_W-1:0]         n_s5 [pcw_pkg::IMG_CNT];
	logic signed [pcw_pkg::Q_W-1:0]    q_s6 [4][3];
	logic [pcw_pkg::NRM_W-1:0]         n_s6 [4];
	logic signed [pcw_pkg::Q_W-1:0]    q_s7 [2][3];
	logic [pcw_pkg::NRM_W-1:0]         n_s7 [2];
	logic signed [pcw_pkg::POS_BITS-1:0] o_s8 [3];
	logic [pcw_pkg::NORM_BITS-1:0]     n_s8;

	logic signed [pcw_pkg::PROD_W-1:0] prod_c [3][3];
	logic signed [pcw_pkg::Q_W-1:0]    q_c [pcw_pkg::IMG_CNT][3];

	function automatic logic signed [pcw_pkg::POS_BITS-1:0] sat(
		logic signed [pcw_pkg::Q_W-1:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		if (w > pcw_pkg::PMAX) w = pcw_pkg::PMAX;
		if (w < pcw_pkg::PMIN) w = pcw_pkg::PMIN;
		return pcw_pkg::POS_BITS'(w);
	endfunction

	assign vor = (mode == pcw_pkg::MODE_VORONOI);

	always_comb begin
		adv[NS-1] = !v_q[NS-1] || res.ready;
		for (int s = NS - 2; s >= 0; s--) begin
			adv[s] = !v_q[s] || adv[s+1];
		end
	end

	assign pop       = avail && adv[0];
	assign res.valid = v_q[NS-1];
	assign res.out_x = o_s8[0];
	assign res.out_y = o_s8[1];
	assign res.out_z = o_s8[2];
	assign res.sq_norm = n_s8;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_c[r][c] = pcw_pkg::mat_entry(cell_rows[r], 2'(c))
					* $signed(pop_data.fr[c]);
			end
		end
	end

	// image k offsets x by k[2], y by k[1], z by k[0]; add cell columns scaled by one
	always_comb begin
		logic signed [pcw_pkg::S_W-1:0] t;
		for (int k = 0; k < pcw_pkg::IMG_CNT; k++) begin
			for (int r = 0; r < 3; r++) begin
				t = sum_s2[r] + RND;
				if (k[2]) t = t + (pcw_pkg::S_W'(pcw_pkg::mat_entry(cell_rows[r], 2'd0))
					<<< pcw_pkg::FRAC_BITS);
				if (k[1]) t = t + (pcw_pkg::S_W'(pcw_pkg::mat_entry(cell_rows[r], 2'd1))
					<<< pcw_pkg::FRAC_BITS);
				if (k[0]) t = t + (pcw_pkg::S_W'(pcw_pkg::mat_entry(cell_rows[r], 2'd2))
					<<< pcw_pkg::FRAC_BITS);
				q_c[k][r] = pcw_pkg::Q_W'(t >>> pcw_pkg::SHIFT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) v_q[0] <= avail;
			for (int s = 1; s < NS; s++) begin
				if (adv[s]) v_q[s] <= v_q[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) prod_s1 <= prod_c;
		if (adv[1]) begin
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= pcw_pkg::S_W'(prod_s1[r][0]) + pcw_pkg::S_W'(prod_s1[r][1])
					+ pcw_pkg::S_W'(prod_s1[r][2]);
			end
		end
		if (adv[2]) q_s3 <= q_c;
		if (adv[3]) begin
			q_s4 <= q_s3;
			for (int k = 0; k < pcw_pkg::IMG_CNT; k++) begin
				for (int r = 0; r < 3; r++) begin
					sq_s4[k][r] <= pcw_pkg::SQ_W'(q_s3[k][r]) * pcw_pkg::SQ_W'(q_s3[k][r]);
				end
			end
		end
		if (adv[4]) begin
			q_s5 <= q_s4;
			for (int k = 0; k < pcw_pkg::IMG_CNT; k++) begin
				n_s5[k] <= pcw_pkg::NRM_W'(sq_s4[k][0]) + pcw_pkg::NRM_W'(sq_s4[k][1])
					+ pcw_pkg::NRM_W'(sq_s4[k][2]);
			end
		end
		// take the later image only when strictly shorter, so ties keep the earlier
		if (adv[5]) begin
			for (int m = 0; m < 4; m++) begin
				if (vor && n_s5[2*m+1] < n_s5[2*m]) begin
					q_s6[m] <= q_s5[2*m+1];
					n_s6[m] <= n_s5[2*m+1];
				end else begin
					q_s6[m] <= q_s5[2*m];
					n_s6[m] <= n_s5[2*m];
				end
			end
		end
		if (adv[6]) begin
			for (int m = 0; m < 2; m++) begin
				if (vor && n_s6[2*m+1] < n_s6[2*m]) begin
					q_s7[m] <= q_s6[2*m+1];
					n_s7[m] <= n_s6[2*m+1];
				end else begin
					q_s7[m] <= q_s6[2*m];
					n_s7[m] <= n_s6[2*m];
				end
			end
		end
		if (adv[7]) begin
			if (vor && n_s7[1] < n_s7[0]) begin
				for (int r = 0; r < 3; r++) o_s8[r] <= sat(q_s7[1][r]);
				n_s8 <= pcw_pkg::NORM_BITS'(n_s7[1]);
			end else begin
				for (int r = 0; r < 3; r++) o_s8[r] <= sat(q_s7[0][r]);
				n_s8 <= pcw_pkg::NORM_BITS'(n_s7[0]);
			end
		end
	end

endmodule

@@ rtl/periodic_cell_wrap_min_image.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_cell_wrap_min_image: periodic wrap with minimum-image search
// Wraps Q16.16 positions into a lattice cell and reports squared length.
// ----------------------------------------------------------------------------
// One position enters per transfer and one result leaves for it, in order.
// The block takes a new position every clock cycle while the queue has room.
// An item passes three front stages (center, inverse-cell products, fraction
// centering), the queue, and eight back stages (cell products, row sums,
// image forming, squares, norm sums, a three-level shortest-image tree that
// also registers the output). Both pipelines hold on back pressure, and the
// four-entry queue between them lets the front keep accepting while the back
// is stalled. Configuration must be written through cfg_we/cfg_idx/cfg_wdata
// only while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module periodic_cell_wrap_min_image (
	input  logic                            clk,
	input  logic                            arst_n,
	pcw_pos_if.sink                         pos,
	pcw_res_if.source                       res,
	input  logic                            cfg_we,
	input  logic [pcw_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [pcw_pkg::REG_W-1:0]       cfg_wdata
);

	// configuration registers, held as the lattice and its inverse by rows
	logic [1:0]          mode_q;
	pcw_pkg::reg_t [2:0] cell_q;
	pcw_pkg::reg_t [2:0] inv_q;
	pcw_pkg::reg_t       center_q;

	// front to queue, queue to back
	logic          push, full, pop, avail;
	pcw_pkg::frv_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= pcw_pkg::MODE_POSITIVE;
			cell_q   <= '0;
			inv_q    <= '0;
			center_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pcw_pkg::REG_MODE:   mode_q    <= cfg_wdata[1:0];
				pcw_pkg::REG_CELL_A: cell_q[0] <= cfg_wdata;
				pcw_pkg::REG_CELL_B: cell_q[1] <= cfg_wdata;
				pcw_pkg::REG_CELL_C: cell_q[2] <= cfg_wdata;
				pcw_pkg::REG_INV_A:  inv_q[0]  <= cfg_wdata;
				pcw_pkg::REG_INV_B:  inv_q[1]  <= cfg_wdata;
				pcw_pkg::REG_INV_C:  inv_q[2]  <= cfg_wdata;
				pcw_pkg::REG_CENTER: center_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: center, map to fractions modulo one, center into [-1/2, 1/2) (positive mode adds one to positive fractions)
	pcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos       (pos),
		.mode      (mode_q),
		.inv       (inv_q),
		.center    (center_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// queue: decouple front stalls from back stalls
	pcw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.avail     (avail),
		.pop_data  (pop_data)
	);

	// back: map to Cartesian, try the images, keep the shortest in Voronoi mode, saturate
	pcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.pop_data  (pop_data),
		.pop       (pop),
		.mode      (mode_q),
		.cell_rows (cell_q),
		.res       (res)
	);

endmodule

@@ tb/tb_periodic_cell_wrap_min_image.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_cell_wrap_min_image: self-checking bench for the periodic wrap
// Drives positions through a series of cell, inverse and center settings,
// predicts each wrapped position and squared norm in fixed point, and
// compares every result transfer in order against the prediction.
// ----------------------------------------------------------------------------

typedef struct {
	logic signed [pcw_pkg::POS_BITS-1:0] x;
	logic signed [pcw_pkg::POS_BITS-1:0] y;
	logic signed [pcw_pkg::POS_BITS-1:0] z;
	logic [pcw_pkg::NORM_BITS-1:0]       nrm;
} wrap_res_t;

class wrap_scoreboard;
	logic [pcw_pkg::REG_W-1:0] cfg_regs [8];
	wrap_res_t                 pending [$];
	int                        errors;

	function new();
		foreach (cfg_regs[i]) cfg_regs[i] = '0;
		errors = 0;
	endfunction

	function void set_reg(int idx, logic [pcw_pkg::REG_W-1:0] val);
		if (idx == pcw_pkg::REG_MODE)
			cfg_regs[idx] = val & 63'd3;
		else
			cfg_regs[idx] = val;
	endfunction

	function longint ent(logic [pcw_pkg::REG_W-1:0] r, int i);
		logic [pcw_pkg::MAT_BITS-1:0] e;
		e = r[i*pcw_pkg::MAT_BITS +: pcw_pkg::MAT_BITS];
		return longint'($signed(e));
	endfunction

	// map a Q.28 fraction vector to Q16.16 through the cell; return Q32.32 norm
	function longint to_cartesian(longint fr [3], output longint q [3]);
		longint s, nrm;
		nrm = 0;
		for (int r = 0; r < 3; r++) begin
			s = 0;
			for (int c = 0; c < 3; c++)
				s += ent(cfg_regs[1 + r], c) * fr[c];
			q[r] = (s + (longint'(1) <<< (pcw_pkg::SHIFT - 1))) >>> pcw_pkg::SHIFT;
			nrm += q[r] * q[r];
		end
		return nrm;
	endfunction

	function void note_position(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		longint    d [3], fr [3], best [3], q [3], o [3];
		longint    bn, nn, v, one, pmax;
		logic [63:0] acc;
		logic [1:0] mode;
		wrap_res_t exp_res;
		one  = longint'(1) <<< pcw_pkg::FRAC_BITS;
		pmax = (longint'(1) <<< (pcw_pkg::POS_BITS - 1)) - 1;
		mode = cfg_regs[pcw_pkg::REG_MODE][1:0];
		d[0] = longint'(px) - ent(cfg_regs[7], 0) * 16;
		d[1] = longint'(py) - ent(cfg_regs[7], 1) * 16;
		d[2] = longint'(pz) - ent(cfg_regs[7], 2) * 16;
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++)
				acc += 64'(ent(cfg_regs[4 + i], j) * d[j]);
			fr[i] = longint'(acc[pcw_pkg::FRAC_BITS-1:0]);
			// center the fraction into [-1/2, 1/2)
			if (fr[i] >= (one >>> 1)) fr[i] -= one;
			if (mode == pcw_pkg::MODE_POSITIVE && fr[i] > 0) fr[i] += one;
		end
		bn = to_cartesian(fr, best);
		if (mode == pcw_pkg::MODE_VORONOI) begin
			for (int a = 0; a < 2; a++)
				for (int b = 0; b < 2; b++)
					for (int c = 0; c < 2; c++) begin
						o[0] = fr[0] + a * one;
						o[1] = fr[1] + b * one;
						o[2] = fr[2] + c * one;
						nn = to_cartesian(o, q);
						// strict compare: ties keep the earlier image
						if (bn > nn) begin
							bn = nn;
							best = q;
						end
					end
		end
		for (int j = 0; j < 3; j++) begin
			v = best[j];
			if (v > pmax) v = pmax;
			if (v < -pmax - 1) v = -pmax - 1;
			best[j] = v;
		end
		if (bn < 0) bn = 64'h7fff_ffff_ffff_ffff;
		exp_res.x   = best[0][31:0];
		exp_res.y   = best[1][31:0];
		exp_res.z   = best[2][31:0];
		exp_res.nrm = bn[62:0];
		pending.push_back(exp_res);
	endfunction

	function void check_result(wrap_res_t act);
		wrap_res_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result x=%h y=%h z=%h n=%h", $time,
				act.x, act.y, act.z, act.nrm);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (act.x !== e.x) begin
			$display("%0t: out_x expected %h actual %h", $time, e.x, act.x);
			errors++;
		end
		if (act.y !== e.y) begin
			$display("%0t: out_y expected %h actual %h", $time, e.y, act.y);
			errors++;
		end
		if (act.z !== e.z) begin
			$display("%0t: out_z expected %h actual %h", $time, e.z, act.z);
			errors++;
		end
		if (act.nrm !== e.nrm) begin
			$display("%0t: sq_norm expected %h actual %h", $time, e.nrm, act.nrm);
			errors++;
		end
	endfunction
endclass

module tb_periodic_cell_wrap_min_image;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 30;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pcw_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [pcw_pkg::REG_W-1:0]     cfg_wdata;

	pcw_pos_if pos_ch();
	pcw_res_if res_ch();

	wrap_scoreboard sb;
	bit  idle_en;     // random gaps on both sides
	bit  hold_req;    // ask the receiver for one long stall
	int  cycles = 0;

	periodic_cell_wrap_min_image DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pos      (pos_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("periodic_cell_wrap_min_image verification failed");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				hold--;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				hold = $urandom_range(0, 9);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// compare every result transfer with the oldest prediction
	always @(posedge clk) begin
		wrap_res_t act;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			act.x   = res_ch.out_x;
			act.y   = res_ch.out_y;
			act.z   = res_ch.out_z;
			act.nrm = res_ch.sq_norm;
			sb.check_result(act);
		end
	end

	function automatic logic [pcw_pkg::REG_W-1:0] pack3(int e0, int e1, int e2);
		return {e2[pcw_pkg::MAT_BITS-1:0], e1[pcw_pkg::MAT_BITS-1:0],
			e0[pcw_pkg::MAT_BITS-1:0]};
	endfunction

	// offer one position; hold it until the transfer completes
	task automatic send_pos(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			pos_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pos_ch.valid <= 1'b1;
		pos_ch.pos_x <= px;
		pos_ch.pos_y <= py;
		pos_ch.pos_z <= pz;
		do @(posedge clk); while (!pos_ch.ready);
		sb.note_position(px, py, pz);
	endtask

	// drop valid, drain everything in flight, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		pos_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [pcw_pkg::CFG_IDX_W-1:0] idx,
			logic [pcw_pkg::REG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic write_all(logic [1:0] mode, logic [pcw_pkg::REG_W-1:0] r [7]);
		write_reg(pcw_pkg::REG_MODE, {61'd0, mode});
		write_reg(pcw_pkg::REG_CELL_A, r[0]);
		write_reg(pcw_pkg::REG_CELL_B, r[1]);
		write_reg(pcw_pkg::REG_CELL_C, r[2]);
		write_reg(pcw_pkg::REG_INV_A, r[3]);
		write_reg(pcw_pkg::REG_INV_B, r[4]);
		write_reg(pcw_pkg::REG_INV_C, r[5]);
		write_reg(pcw_pkg::REG_CENTER, r[6]);
	endtask

	// consistent cell: diagonal lengths with matching inverse, small shear
	task automatic pick_physical(output logic [pcw_pkg::REG_W-1:0] r [7]);
		int len [3];
		int inv [3];
		int sh;
		for (int i = 0; i < 3; i++) begin
			len[i] = $urandom_range(2048, 65536);        // 0.5 .. 16
			inv[i] = (4096 * 4096) / len[i];
		end
		sh = $urandom_range(0, 2048) - 1024;
		r[0] = pack3(len[0], sh, 0);
		r[1] = pack3(0, len[1], 0);
		r[2] = pack3(0, 0, len[2]);
		r[3] = pack3(inv[0], -((sh * inv[0]) / len[1]), 0);
		r[4] = pack3(0, inv[1], 0);
		r[5] = pack3(0, 0, inv[2]);
		r[6] = pack3($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
			$urandom_range(0, 8191) - 4096);
	endtask

	function automatic logic [31:0] rand_pos(bit near);
		if (near) return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		return $urandom;
	endfunction

	logic [pcw_pkg::REG_W-1:0] regs_set [7];
	logic [31:0] dir_vals [12];
	int k;

	initial begin
		sb        = new();
		idle_en   = 1'b1;
		hold_req  = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		pos_ch.valid = 1'b0;
		pos_ch.pos_x = '0;
		pos_ch.pos_y = '0;
		pos_ch.pos_z = '0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: zero matrices, every norm ties at zero
		send_pos(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
		send_pos(32'h0, 32'hffff_ffff, 32'h1234_5678);
		drain();

		// directed: field extremes under each mode, including the unused one
		dir_vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'h0008_0000,
			32'hfff8_0000, 32'h5555_5555, 32'haaaa_aaaa};
		for (int m = 0; m < 4; m++) begin
			pick_physical(regs_set);
			write_all(m[1:0], regs_set);
			for (int i = 0; i < 6; i++)
				send_pos(dir_vals[(2 * i + m) % 12], dir_vals[(2 * i + 1 + m) % 12],
					dir_vals[(i + 5 * m) % 12]);
			drain();
		end

		// extreme matrix entries: all max positive, then all most negative
		for (int i = 0; i < 7; i++) regs_set[i] = pack3(20'hf_ffff, 20'hf_ffff, 20'hf_ffff);
		write_all(pcw_pkg::MODE_VORONOI, regs_set);
		for (int i = 0; i < 4; i++) send_pos(dir_vals[i + 1], dir_vals[i + 3], dir_vals[i]);
		drain();
		for (int i = 0; i < 7; i++)
			regs_set[i] = pack3(-(1 << 20), -(1 << 20), -(1 << 20));
		write_all(pcw_pkg::MODE_POSITIVE, regs_set);
		for (int i = 0; i < 4; i++) send_pos(dir_vals[i + 4], dir_vals[i], dir_vals[i + 2]);
		drain();

		// random settings, one of them with a long receiver hold-off
		for (int ph = 0; ph < 10; ph++) begin
			k = $urandom_range(0, 3);
			if (k == 0) begin
				for (int i = 0; i < 7; i++)
					regs_set[i] = pcw_pkg::REG_W'({$urandom, $urandom});
			end else begin
				pick_physical(regs_set);
			end
			write_all(2'($urandom_range(0, 3)), regs_set);
			if (ph == 1) hold_req = 1'b1;
			if (ph == 9) idle_en = 1'b0;   // last stretch runs at full rate
			for (int i = 0; i < 70; i++) begin
				k = $urandom_range(0, 2);
				send_pos(rand_pos(k != 0), rand_pos(k != 0), rand_pos(k != 0));
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("periodic_cell_wrap_min_image verification clean");
		else
			$display("periodic_cell_wrap_min_image verification failed");
		$finish;
	end

endmodule
